FILE: rtl/ptf_pkg.sv
// shared types, constants and register indexes of the pedal torque filter
package ptf_pkg;

  // default scales
  localparam int SLOPE_SCALE_DEF   = 1024;
  localparam int PERCENT_SCALE_DEF = 100;

  localparam int SAMPLE_W  = 16;
  localparam int SPEED_W   = 8;
  localparam int PCT_W     = 7;
  localparam int DIVS_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  localparam logic [15:0] SAMPLE_CLAMP = 16'hFFFE;
  localparam logic [15:0] MAX16        = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_OFFSET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_SLOPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAFETY_PCT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_BOUNDS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_DIVS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_DIVS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_LIMIT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT   = 3'd7;

  // register reset values
  localparam logic [15:0]       RST_IDLE_OFFSET  = 16'd0;
  localparam logic [15:0]       RST_SENSOR_SLOPE = 16'd1024;
  localparam logic [PCT_W-1:0]  RST_SAFETY_PCT   = 7'd10;
  localparam logic [15:0]       RST_SPEED_BOUNDS = 16'd0;
  localparam logic [DIVS_W-1:0] RST_DIVS         = 48'h0001_0001_0001;
  localparam logic [15:0]       RST_SAFE_LIMIT   = 16'd100;
  localparam logic [15:0]       RST_STUCK_LIMIT  = 16'd5000;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_ACC,
    MUL_TRQ,
    MUL_THR
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    logic     div_load_avg;
    logic     div_load_trq;
    logic     store_avg;
    logic     store_trq;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

FILE: rtl/ptf_ifs.sv
// handshake channel interfaces: sample input, result output, register write

interface ptf_in_if;
  logic                              valid;
  logic                              ready;
  logic [ptf_pkg::SAMPLE_W-1:0]      adc_sample;
  logic [ptf_pkg::SPEED_W-1:0]       speed;
  modport source (output valid, output adc_sample, output speed, input ready);
  modport sink   (input valid, input adc_sample, input speed, output ready);
endinterface

interface ptf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] torque;
  logic [15:0] filtered_adc;
  logic        safe_started;
  logic        boot_error;
  modport source (output valid, output torque, output filtered_adc, output safe_started,
                  output boot_error, input ready);
  modport sink   (input valid, input torque, input filtered_adc, input safe_started,
                  input boot_error, output ready);
endinterface

interface ptf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ptf_pkg::CFG_IDX_W-1:0]     index;
  logic [ptf_pkg::CFG_DAT_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/pedal_torque_filter_safe_start.sv
// top level of the pedal torque filter with safe-start check
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    adc_sample[15:0], speed[7:0]
//   out_ch   out  valid/ready    torque[15:0], filtered_adc[15:0], safe_started, boot_error
//   cfg_ch   in   valid/ready    index[2:0], data[47:0]; ready is always high
//
// one word at a time: the next word is taken only once the controller is back in idle
// after the commit step; the shared 32/16 divider is run twice per word
// rst_n is synchronous; it restores register defaults and clears filter state
// a result waiting on out_ch does not block the next accept; only the final commit
// step waits for the output register to free up
module pedal_torque_filter_safe_start #(
  parameter int SLOPE_SCALE   = ptf_pkg::SLOPE_SCALE_DEF,
  parameter int PERCENT_SCALE = ptf_pkg::PERCENT_SCALE_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ptf_in_if.sink    in_ch,
  ptf_out_if.source out_ch,
  ptf_cfg_if.sink   cfg_ch
);

  ptf_pkg::cmd_t cmd;
  ptf_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  ptf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptf_dp #(
    .SLOPE_SCALE   (SLOPE_SCALE),
    .PERCENT_SCALE (PERCENT_SCALE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_adc_sample    (in_ch.adc_sample),
    .in_speed         (in_ch.speed),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_torque       (out_ch.torque),
    .out_filtered_adc (out_ch.filtered_adc),
    .out_safe_started (out_ch.safe_started),
    .out_boot_error   (out_ch.boot_error)
  );

endmodule

FILE: rtl/ptf_div.sv
// iterative 32/16 divider, two quotient bits per cycle, 16-bit quotient
module ptf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] quotient
);

  localparam int STEPS = 8;

  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dq_r, dq_nxt;
  logic [15:0] dvs_r;
  logic [2:0]  cnt_r;
  logic        busy_r;

  // two restoring steps; upper dividend half must be below the divisor
  always_comb begin
    logic [16:0] t;
    logic        q;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    for (int i = 0; i < 2; i++) begin
      t = {rem_nxt, dq_nxt[15]};
      q = (t >= {1'b0, dvs_r});
      if (q) begin
        t = t - {1'b0, dvs_r};
      end
      rem_nxt = t[15:0];
      dq_nxt  = {dq_nxt[14:0], q};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == 3'(STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[31:16];
      dq_r  <= dividend[15:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule

FILE: rtl/ptf_dp.sv
// datapath: config registers, averaging, torque scaling, safe-start state
module ptf_dp #(
  parameter int SLOPE_SCALE   = ptf_pkg::SLOPE_SCALE_DEF,
  parameter int PERCENT_SCALE = ptf_pkg::PERCENT_SCALE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptf_pkg::cmd_t                 cmd,
  output ptf_pkg::sts_t                 sts,
  input  logic [ptf_pkg::SAMPLE_W-1:0]  in_adc_sample,
  input  logic [ptf_pkg::SPEED_W-1:0]   in_speed,
  input  logic                          cfg_we,
  input  logic [ptf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptf_pkg::CFG_DAT_W-1:0] cfg_data,
  output logic [15:0]                   out_torque,
  output logic [15:0]                   out_filtered_adc,
  output logic                          out_safe_started,
  output logic                          out_boot_error
);

  localparam logic [15:0] SLOPE_DIV = 16'(SLOPE_SCALE);
  localparam logic [15:0] PCT_DIV   = 16'(PERCENT_SCALE);

  // configuration registers
  logic [15:0]                  idle_off_r, slope_r, bounds_r, safe_lim_r, stuck_lim_r;
  logic [ptf_pkg::PCT_W-1:0]    pct_r;
  logic [ptf_pkg::DIVS_W-1:0]   rise_r, fall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_off_r  <= ptf_pkg::RST_IDLE_OFFSET;
      slope_r     <= ptf_pkg::RST_SENSOR_SLOPE;
      pct_r       <= ptf_pkg::RST_SAFETY_PCT;
      bounds_r    <= ptf_pkg::RST_SPEED_BOUNDS;
      rise_r      <= ptf_pkg::RST_DIVS;
      fall_r      <= ptf_pkg::RST_DIVS;
      safe_lim_r  <= ptf_pkg::RST_SAFE_LIMIT;
      stuck_lim_r <= ptf_pkg::RST_STUCK_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        ptf_pkg::REG_IDLE_OFFSET:  idle_off_r  <= cfg_data[15:0];
        ptf_pkg::REG_SENSOR_SLOPE: slope_r     <= cfg_data[15:0];
        ptf_pkg::REG_SAFETY_PCT:   pct_r       <= cfg_data[ptf_pkg::PCT_W-1:0];
        ptf_pkg::REG_SPEED_BOUNDS: bounds_r    <= cfg_data[15:0];
        ptf_pkg::REG_RISE_DIVS:    rise_r      <= cfg_data[ptf_pkg::DIVS_W-1:0];
        ptf_pkg::REG_FALL_DIVS:    fall_r      <= cfg_data[ptf_pkg::DIVS_W-1:0];
        ptf_pkg::REG_SAFE_LIMIT:   safe_lim_r  <= cfg_data[15:0];
        ptf_pkg::REG_STUCK_LIMIT:  stuck_lim_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // filter state
  logic [15:0] avg_r, d_r, s_r, tq_r;
  logic [32:0] prod_r;
  logic        sat_r;

  // divisor pick from band and direction
  logic [ptf_pkg::DIVS_W-1:0] pack;
  logic [15:0]                d_sel;
  always_comb begin
    pack = (in_adc_sample > avg_r) ? rise_r : fall_r;
    if (in_speed < bounds_r[7:0]) begin
      d_sel = pack[15:0];
    end else if (in_speed < bounds_r[15:8]) begin
      d_sel = pack[31:16];
    end else begin
      d_sel = pack[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      d_r <= (d_sel == 16'd0) ? 16'd1 : d_sel;
      s_r <= (in_adc_sample == ptf_pkg::MAX16) ? ptf_pkg::SAMPLE_CLAMP : in_adc_sample;
    end
  end

  // shared multiplier
  logic [15:0] lvl;
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] mul_p;

  assign lvl = (avg_r > idle_off_r) ? (avg_r - idle_off_r) : 16'd0;

  always_comb begin
    case (cmd.mul_sel)
      ptf_pkg::MUL_ACC: begin
        mul_a = {1'b0, d_r - 16'd1};
        mul_b = avg_r;
      end
      ptf_pkg::MUL_TRQ: begin
        mul_a = {1'b0, lvl};
        mul_b = slope_r;
      end
      ptf_pkg::MUL_THR: begin
        mul_a = {1'b0, tq_r} + 17'd1;
        mul_b = PCT_DIV;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != ptf_pkg::MUL_NONE) begin
      prod_r <= mul_p;
    end
  end

  // divider
  logic        div_start, div_busy;
  logic [31:0] div_dvd;
  logic [15:0] div_dvs, div_q;

  assign div_start = cmd.div_load_avg | cmd.div_load_trq;
  assign div_dvd   = cmd.div_load_avg ? (prod_r[31:0] + {16'd0, s_r}) : prod_r[31:0];
  assign div_dvs   = cmd.div_load_avg ? d_r : SLOPE_DIV;

  ptf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign sts.div_busy = div_busy;

  always_ff @(posedge clk) begin
    if (cmd.div_load_trq) begin
      // quotient would exceed 16 bits
      sat_r <= (prod_r[31:16] >= SLOPE_DIV);
    end
    if (cmd.store_trq) begin
      tq_r <= sat_r ? ptf_pkg::MAX16 : div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (cmd.store_avg) begin
      avg_r <= div_q;
    end
  end

  // safe-start bookkeeping
  logic        safe_r, err_r, latch_r;
  logic [15:0] lrc_r, stk_r;
  logic        safe_nxt, err_nxt, latch_nxt;
  logic [15:0] lrc_nxt, stk_nxt, lrc_inc, stk_inc, tq_out;
  logic [22:0] thr_x;
  logic        low;

  always_comb begin
    // tq < floor(65535*pct/scale)  <=>  (tq+1)*scale <= 65535*pct
    thr_x     = {pct_r, 16'h0000} - {16'h0000, pct_r};
    low       = (prod_r <= {10'd0, thr_x});
    lrc_inc   = (lrc_r != ptf_pkg::MAX16) ? lrc_r + 16'd1 : lrc_r;
    stk_inc   = (stk_r != ptf_pkg::MAX16) ? stk_r + 16'd1 : stk_r;
    safe_nxt  = safe_r;
    err_nxt   = err_r;
    latch_nxt = latch_r;
    lrc_nxt   = lrc_r;
    stk_nxt   = stk_r;
    tq_out    = tq_r;
    if (!safe_r) begin
      if (low) begin
        lrc_nxt = lrc_inc;
        if (lrc_inc >= safe_lim_r) begin
          safe_nxt = 1'b1;
          err_nxt  = 1'b0;
          stk_nxt  = 16'd0;
        end else begin
          tq_out = 16'd0;
        end
      end else begin
        lrc_nxt = 16'd0;
        tq_out  = 16'd0;
        if (!latch_r) begin
          stk_nxt = stk_inc;
          if (stk_inc >= stuck_lim_r) begin
            err_nxt   = 1'b1;
            latch_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_r  <= 1'b0;
      err_r   <= 1'b0;
      latch_r <= 1'b0;
      lrc_r   <= '0;
      stk_r   <= '0;
    end else if (cmd.commit) begin
      safe_r  <= safe_nxt;
      err_r   <= err_nxt;
      latch_r <= latch_nxt;
      lrc_r   <= lrc_nxt;
      stk_r   <= stk_nxt;
    end
  end

  // output word register
  logic [15:0] o_tq_r, o_avg_r;
  logic        o_safe_r, o_err_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_tq_r   <= tq_out;
      o_avg_r  <= avg_r;
      o_safe_r <= safe_nxt;
      o_err_r  <= err_nxt;
    end
  end

  assign out_torque       = o_tq_r;
  assign out_filtered_adc = o_avg_r;
  assign out_safe_started = o_safe_r;
  assign out_boot_error   = o_err_r;

endmodule

FILE: rtl/ptf_ctrl.sv
// controller: sequences one word through multiply, divide and commit steps
module ptf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ptf_pkg::sts_t sts,
  output ptf_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_ACC,
    S_LOAD_AVG,
    S_DIV_AVG,
    S_STORE_AVG,
    S_MUL_TRQ,
    S_LOAD_TRQ,
    S_DIV_TRQ,
    S_STORE_TRQ,
    S_MUL_THR,
    S_COMMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.mul_sel = ptf_pkg::MUL_NONE;
    case (state_r)
      S_IDLE:      cmd.load_in      = in_valid;
      S_MUL_ACC:   cmd.mul_sel      = ptf_pkg::MUL_ACC;
      S_LOAD_AVG:  cmd.div_load_avg = 1'b1;
      S_STORE_AVG: cmd.store_avg    = 1'b1;
      S_MUL_TRQ:   cmd.mul_sel      = ptf_pkg::MUL_TRQ;
      S_LOAD_TRQ:  cmd.div_load_trq = 1'b1;
      S_STORE_TRQ: cmd.store_trq    = 1'b1;
      S_MUL_THR:   cmd.mul_sel      = ptf_pkg::MUL_THR;
      S_COMMIT:    cmd.commit       = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_COMMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE:      if (in_valid) state_r <= S_MUL_ACC;
        S_MUL_ACC:   state_r <= S_LOAD_AVG;
        S_LOAD_AVG:  state_r <= S_DIV_AVG;
        S_DIV_AVG:   if (!sts.div_busy) state_r <= S_STORE_AVG;
        S_STORE_AVG: state_r <= S_MUL_TRQ;
        S_MUL_TRQ:   state_r <= S_LOAD_TRQ;
        S_LOAD_TRQ:  state_r <= S_DIV_TRQ;
        S_DIV_TRQ:   if (!sts.div_busy) state_r <= S_STORE_TRQ;
        S_STORE_TRQ: state_r <= S_MUL_THR;
        S_MUL_THR:   state_r <= S_COMMIT;
        S_COMMIT:    if (slot_free) state_r <= S_IDLE;
        default:     state_r <= S_IDLE;
      endcase
    end
  end

endmodule
